@@ rtl/tsp_pkg.sv @@
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, codes and constants of the tone sequence player.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int STORE_DEPTH_DEF = 256;
    localparam int TONE_W          = 32;
    localparam int OCT_W           = 10;
    localparam int SHIFT_W         = $clog2(TONE_W);

    localparam logic signed [OCT_W-1:0] OCT_MAX = OCT_W'(511);
    localparam logic signed [OCT_W-1:0] OCT_MIN = OCT_W'(-512);

    // request operations
    typedef enum logic [2:0] {
        OP_BEGIN  = 3'd0,
        OP_SYMBOL = 3'd1,
        OP_COMMIT = 3'd2,
        OP_TICK   = 3'd3,
        OP_STOP   = 3'd4
    } t_op;

    // speaker actions
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_START   = 2'd1,
        ACT_SILENCE = 2'd2
    } t_act;

    // work handed from the front stage to the result stage
    typedef enum logic [1:0] {
        K_NONE,
        K_PLAY,
        K_IDLE,
        K_STOP
    } t_kind;

    typedef struct packed {
        logic signed [OCT_W-1:0] octave;
        logic [TONE_W-1:0]       tone;
    } t_sym_state;

    // character codes
    localparam logic [7:0] CH_UP    = 8'h3E;
    localparam logic [7:0] CH_DOWN  = 8'h3C;
    localparam logic [7:0] CH_OCT   = 8'h6F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_C = 8'h63;
    localparam logic [7:0] CH_LOW_D = 8'h64;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_G = 8'h67;

    // base tone values of the notes
    localparam logic [TONE_W-1:0] TONE_A = TONE_W'(28);
    localparam logic [TONE_W-1:0] TONE_B = TONE_W'(30);
    localparam logic [TONE_W-1:0] TONE_C = TONE_W'(16);
    localparam logic [TONE_W-1:0] TONE_D = TONE_W'(18);
    localparam logic [TONE_W-1:0] TONE_E = TONE_W'(20);
    localparam logic [TONE_W-1:0] TONE_F = TONE_W'(22);
    localparam logic [TONE_W-1:0] TONE_G = TONE_W'(24);

    // letters differ from their capitals only in the case bit
    function automatic logic [TONE_W-1:0] note_base(input logic [7:0] sym);
        logic [7:0] low;
        low = sym | CH_CASE;
        case (low)
            CH_LOW_A: note_base = TONE_A;
            CH_LOW_B: note_base = TONE_B;
            CH_LOW_C: note_base = TONE_C;
            CH_LOW_D: note_base = TONE_D;
            CH_LOW_E: note_base = TONE_E;
            CH_LOW_F: note_base = TONE_F;
            CH_LOW_G: note_base = TONE_G;
            default:  note_base = '0;
        endcase
    endfunction

endpackage

@@ rtl/tsp_req_if.sv @@
// ----------------------------------------------------------------------------
// tsp_req_if
// Request channel of the tone sequence player.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsp_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        operation;
    logic [7:0]        symbol;
    logic signed [7:0] next_symbol;

    modport source (output valid, operation, symbol, next_symbol, input ready);
    modport sink   (input valid, operation, symbol, next_symbol, output ready);
endinterface

@@ rtl/tsp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// tsp_rsp_if
// Result channel of the tone sequence player.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tsp_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  speaker_action;
    logic [31:0] tone_value;

    modport source (output valid, speaker_action, tone_value, input ready);
    modport sink   (input valid, speaker_action, tone_value, output ready);
endinterface

@@ rtl/tone_sequence_player.sv @@
// ----------------------------------------------------------------------------
// tone_sequence_player
// Builds a tone list from note string characters and plays it one entry per
// tick.
// The front stage updates the list state and reads the tone store, the
// result stage compares with the last tone, then the output register holds
// the result. Throughput: one request per cycle while o_rsp is not stalled.
// Reset: synchronous, clears the octave, tone, counts, indices and the last
// tone; the tone store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tone_sequence_player
    import tsp_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tsp_req_if.sink   i_req,
    tsp_rsp_if.source o_rsp
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int EW = AW + 1;

    // list state
    logic [CW-1:0]           r_entry_count, n_entry_count;
    logic signed [OCT_W-1:0] r_octave;
    logic [TONE_W-1:0]       r_tone;
    t_sym_state              n_sym;
    logic [AW-1:0]           r_play_index, n_play_index;
    logic signed [EW-1:0]    r_end_index, n_end_index;
    logic [TONE_W-1:0]       r_last_tone, n_last_tone;
    logic                    r_last_valid, n_last_valid;

    // pipeline
    logic                    r_s2_valid;
    t_kind                   r_s2_kind, n_kind;
    logic                    r_out_valid;
    t_act                    r_out_action, n_out_action;
    logic [TONE_W-1:0]       r_out_tone, n_out_tone;

    logic                    w_out_en;
    logic                    w_s2_en;
    logic                    w_acc;
    logic                    w_is_sym;
    logic                    w_clear_count;
    logic [CW-1:0]           w_base_count;
    logic                    w_wr_en;
    logic [AW-1:0]           w_rd_addr;
    logic [TONE_W-1:0]       w_rd_data;
    logic                    w_play_lt_end;
    t_sym_state              w_sym_cur;

    assign w_out_en    = !r_out_valid || o_rsp.ready;
    assign w_s2_en     = !r_s2_valid || w_out_en;
    assign w_acc       = i_req.valid && w_s2_en;
    assign i_req.ready = w_s2_en;

    assign w_sym_cur.octave = r_octave;
    assign w_sym_cur.tone   = r_tone;

    tsp_sym_dec u_sym_dec (
        .i_state       (w_sym_cur),
        .i_symbol      (i_req.symbol),
        .i_next_symbol (i_req.next_symbol),
        .o_state       (n_sym),
        .o_clear_count (w_clear_count)
    );

    assign w_is_sym      = (i_req.operation == OP_SYMBOL);
    assign w_base_count  = w_clear_count ? '0 : r_entry_count;
    assign w_wr_en       = w_acc && w_is_sym && (w_base_count < CW'(STORE_DEPTH));
    assign w_play_lt_end = $signed({1'b0, r_play_index}) < r_end_index;
    assign w_rd_addr     = r_play_index + AW'(1);

    tsp_ram #(
        .WIDTH (TONE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_base_count[AW-1:0]),
        .i_wr_data (n_sym.tone),
        .i_rd_en   (w_s2_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // front stage: list state and store access
    always_comb begin
        n_entry_count = r_entry_count;
        n_play_index  = r_play_index;
        n_end_index   = r_end_index;
        n_kind        = K_NONE;
        unique case (i_req.operation)
            OP_BEGIN: begin
                n_entry_count = '0;
            end
            OP_SYMBOL: begin
                n_entry_count = w_base_count;
                if (w_base_count < CW'(STORE_DEPTH)) begin
                    n_entry_count = w_base_count + CW'(1);
                end
            end
            OP_COMMIT: begin
                if (!((r_play_index == '0) && (r_end_index != '0))) begin
                    n_play_index = '0;
                    n_end_index  = EW'(r_entry_count) - EW'(1);
                end
            end
            OP_TICK: begin
                if (w_play_lt_end && (r_entry_count != '0)) begin
                    n_play_index = w_rd_addr;
                    n_kind       = K_PLAY;
                end else begin
                    n_play_index = '0;
                    n_end_index  = '0;
                    n_kind       = K_IDLE;
                end
            end
            OP_STOP: begin
                n_play_index = '0;
                n_end_index  = '0;
                n_kind       = K_STOP;
            end
            default: begin
            end
        endcase
    end

    // result stage: compare with the tone last driven
    always_comb begin
        n_out_action = ACT_NONE;
        n_out_tone   = '0;
        n_last_tone  = r_last_tone;
        n_last_valid = r_last_valid;
        case (r_s2_kind)
            K_PLAY: begin
                if (!r_last_valid || (w_rd_data != r_last_tone)) begin
                    n_out_action = ACT_START;
                    n_out_tone   = w_rd_data;
                end
                n_last_tone  = w_rd_data;
                n_last_valid = 1'b1;
            end
            K_IDLE: begin
                n_out_action = ACT_SILENCE;
                n_last_valid = 1'b0;
            end
            K_STOP: begin
                n_out_action = ACT_SILENCE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_octave      <= '0;
            r_tone        <= '0;
            r_play_index  <= '0;
            r_end_index   <= '0;
            r_last_tone   <= '0;
            r_last_valid  <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_s2_kind     <= K_NONE;
            r_out_valid   <= 1'b0;
            r_out_action  <= ACT_NONE;
        end else begin
            if (w_acc) begin
                r_entry_count <= n_entry_count;
                r_play_index  <= n_play_index;
                r_end_index   <= n_end_index;
                if (i_req.operation == OP_BEGIN) begin
                    r_octave <= '0;
                    r_tone   <= '0;
                end else if (w_is_sym) begin
                    r_octave <= n_sym.octave;
                    r_tone   <= n_sym.tone;
                end
            end
            if (w_s2_en) begin
                r_s2_valid <= i_req.valid;
                r_s2_kind  <= n_kind;
            end
            if (w_out_en) begin
                r_out_valid  <= r_s2_valid;
                r_out_action <= n_out_action;
                if (r_s2_valid) begin
                    r_last_tone  <= n_last_tone;
                    r_last_valid <= n_last_valid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_out_tone <= n_out_tone;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.speaker_action = r_out_action;
    assign o_rsp.tone_value     = r_out_tone;

    // list never grows past the store
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CW'(STORE_DEPTH))
        else $error("entry count beyond store depth");

    // play position stays within a committed tune
    a_play_in_tune: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_end_index >= 0) |-> ($signed({1'b0, r_play_index}) <= r_end_index))
        else $error("play index past end index");

    // a stop request rewinds the tune
    a_stop_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_req.operation == OP_STOP))
        |=> ((r_play_index == '0) && (r_end_index == '0)))
        else $error("stop did not rewind");

    // only a start carries a tone
    a_tone_only_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_action != ACT_START)) |-> (r_out_tone == '0))
        else $error("tone value without start");

    // a sounding tone is only ever left by an idle tick
    a_last_valid_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_last_valid) |-> $past(r_s2_valid && (r_s2_kind == K_IDLE) && w_out_en))
        else $error("last tone dropped without idle tick");

endmodule

@@ rtl/tsp_ram.sv @@
// ----------------------------------------------------------------------------
// tsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/tsp_sym_dec.sv @@
// ----------------------------------------------------------------------------
// tsp_sym_dec
// Applies one note string character to the octave and the running tone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsp_sym_dec
    import tsp_pkg::*;
(
    input  t_sym_state        i_state,
    input  logic [7:0]        i_symbol,
    input  logic signed [7:0] i_next_symbol,
    output t_sym_state        o_state,
    output logic              o_clear_count
);

    logic signed [OCT_W-1:0] w_oct;
    logic [TONE_W-1:0]       w_tone;
    logic signed [OCT_W-1:0] w_next_ext;

    assign w_next_ext = {{(OCT_W-8){i_next_symbol[7]}}, i_next_symbol};

    always_comb begin
        w_oct         = i_state.octave;
        w_tone        = i_state.tone;
        o_clear_count = 1'b0;
        unique case (i_symbol)
            CH_UP: begin
                if (i_state.octave != OCT_MAX) w_oct = i_state.octave + OCT_W'(1);
            end
            CH_DOWN: begin
                if (i_state.octave != OCT_MIN) w_oct = i_state.octave - OCT_W'(1);
            end
            CH_OCT: begin
                w_oct = w_next_ext - OCT_W'(CH_ZERO);
            end
            CH_SEMI: begin
                w_tone        = '0;
                o_clear_count = 1'b1;
            end
            default: begin
                w_tone = note_base(i_symbol);
            end
        endcase

        o_state.octave = w_oct;
        o_state.tone   = w_tone;
        // positive octave shifts the tone up, 32 or more clears it
        if (!w_oct[OCT_W-1] && (w_oct != '0)) begin
            if (|w_oct[OCT_W-2:SHIFT_W]) begin
                o_state.tone = '0;
            end else begin
                o_state.tone = w_tone << w_oct[SHIFT_W-1:0];
            end
        end
    end

endmodule
